[sv/psp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg
// shared character codes, field widths and helpers for the printf
// conversion specifier parser
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam int CHAR_W   = 8;
  localparam int FLAGS_W  = 6;
  localparam int NUM_W    = 16;
  localparam int LEVEL_W  = 2;
  localparam int COUNT_W  = 8;
  localparam int RESULT_W = 64;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6C;
  localparam logic [CHAR_W-1:0] CH_BIG_L = 8'h4C;

  localparam int FLAG_MINUS = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_HASH  = 2;
  localparam int FLAG_ZERO  = 3;
  localparam int FLAG_SPACE = 4;
  localparam int FLAG_ANY   = 5;

  localparam logic [LEVEL_W-1:0] LEVEL_NONE   = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_SINGLE = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_DOUBLE = 2'd2;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // acc * 10 + digit, saturating at the top of the field
  function automatic logic [NUM_W-1:0] dec_acc(input logic [NUM_W-1:0] acc,
                                               input logic [CHAR_W-1:0] c);
    logic [NUM_W+3:0] v;
    logic [CHAR_W-1:0] d;
    d = c - CH_ZERO;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(NUM_W-4){1'b0}}, d};
    return (|v[NUM_W+3:NUM_W]) ? {NUM_W{1'b1}} : v[NUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/printf_spec_parser_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// printf_spec_parser_core
// parses the bytes after a percent sign into one result per specifier
// ----------------------------------------------------------------------------
// Takes one specifier byte per cycle on s_axis and updates the parse state
// (flags, width, dot, precision digits, length modifiers) with combinational
// logic. The byte that fits no open phase is the conversion type: it
// loads the result register, which drives m_axis, and the parse state
// returns to its reset values, so the next byte starts a new specifier.
// tuser high on an input item clears the parse state before that byte is
// taken. Input is accepted every cycle unless a result sits in the output
// register and m_axis_tready is low; the result appears in the cycle after its
// type byte is accepted.
module printf_spec_parser_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_in
  input  wire logic        s_axis_tuser,  // [0] start_req
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [5:0] flags, [21:6] min_width, [37:22] precision, [39:38] mod_short,
  // [41:40] mod_long, [42] mod_long_double, [50:43] conv_type,
  // [58:51] consumed, [63:59] zero
  output logic [63:0]      m_axis_tdata
);

  typedef enum logic [2:0] {
    PH_FLAGS,
    PH_WIDTH,
    PH_DOT,
    PH_PDIG,
    PH_MODS
  } phase_t;

  typedef enum logic [1:0] {
    PM_NONE,
    PM_H,
    PM_L,
    PM_BIGL
  } prev_mod_t;

  typedef struct packed {
    phase_t                              phase;
    logic [psp_pkg::FLAGS_W-1:0]         flag_bits;
    logic [psp_pkg::NUM_W-1:0]           width_acc;
    logic [psp_pkg::NUM_W-1:0]           prec_acc;
    logic                                prec_negative;
    logic [psp_pkg::LEVEL_W-1:0]         short_level;
    logic [psp_pkg::LEVEL_W-1:0]         long_level;
    logic                                big_l_seen;
    prev_mod_t                           prev_modifier;
    logic [psp_pkg::COUNT_W-1:0]         count;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:         PH_FLAGS,
    flag_bits:     '0,
    width_acc:     '0,
    prec_acc:      '0,
    prec_negative: 1'b0,
    short_level:   psp_pkg::LEVEL_NONE,
    long_level:    psp_pkg::LEVEL_NONE,
    big_l_seen:    1'b0,
    prev_modifier: PM_NONE,
    count:         '0
  };

  parse_t                          st;
  parse_t                          st_next;
  logic                            emit;
  logic [psp_pkg::RESULT_W-1:0]    result_next;
  logic                            in_fire;
  logic [psp_pkg::CHAR_W-1:0]      c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    parse_t                          w;
    logic                            done;
    logic [psp_pkg::FLAGS_W-1:0]     f;
    logic [psp_pkg::NUM_W-1:0]       prec_out;

    w    = s_axis_tuser ? PARSE_RESET : st;
    done = 1'b0;
    emit = 1'b0;
    if (w.count != {psp_pkg::COUNT_W{1'b1}}) begin
      w.count = w.count + {{(psp_pkg::COUNT_W-1){1'b0}}, 1'b1};
    end

    if (w.phase == PH_FLAGS) begin
      unique case (c)
        psp_pkg::CH_MINUS: begin
          w.flag_bits[psp_pkg::FLAG_MINUS] = 1'b1;
          done = 1'b1;
        end
        psp_pkg::CH_PLUS: begin
          w.flag_bits[psp_pkg::FLAG_PLUS] = 1'b1;
          done = 1'b1;
        end
        psp_pkg::CH_HASH: begin
          w.flag_bits[psp_pkg::FLAG_HASH] = 1'b1;
          done = 1'b1;
        end
        psp_pkg::CH_ZERO: begin
          w.flag_bits[psp_pkg::FLAG_ZERO] = 1'b1;
          done = 1'b1;
        end
        psp_pkg::CH_SPACE: begin
          w.flag_bits[psp_pkg::FLAG_SPACE] = 1'b1;
          done = 1'b1;
        end
        default: w.phase = PH_WIDTH;
      endcase
      if (done) begin
        w.flag_bits[psp_pkg::FLAG_ANY] = 1'b1;
      end
    end

    if (!done && w.phase == PH_WIDTH) begin
      priority if (psp_pkg::is_digit(c)) begin
        w.width_acc = psp_pkg::dec_acc(w.width_acc, c);
        done = 1'b1;
      end else if (c == psp_pkg::CH_DOT) begin
        w.phase = PH_DOT;
        done = 1'b1;
      end else begin
        w.phase = PH_MODS;
      end
    end

    if (!done && w.phase == PH_DOT) begin
      w.phase = PH_PDIG;
      if (c == psp_pkg::CH_MINUS) begin
        w.prec_negative = 1'b1;
        done = 1'b1;
      end
    end

    if (!done && w.phase == PH_PDIG) begin
      if (psp_pkg::is_digit(c)) begin
        w.prec_acc = psp_pkg::dec_acc(w.prec_acc, c);
        done = 1'b1;
      end else begin
        w.phase = PH_MODS;
      end
    end

    // modifier phase; a second h or l right after the same one doubles it
    if (!done) begin
      priority if (c == psp_pkg::CH_H) begin
        if (w.prev_modifier == PM_H) begin
          w.short_level = psp_pkg::LEVEL_DOUBLE;
        end else if (w.short_level != psp_pkg::LEVEL_DOUBLE) begin
          w.short_level = psp_pkg::LEVEL_SINGLE;
        end
        w.prev_modifier = PM_H;
      end else if (c == psp_pkg::CH_L) begin
        if (w.prev_modifier == PM_L) begin
          w.long_level = psp_pkg::LEVEL_DOUBLE;
        end else if (w.long_level != psp_pkg::LEVEL_DOUBLE) begin
          w.long_level = psp_pkg::LEVEL_SINGLE;
        end
        w.prev_modifier = PM_L;
      end else if (c == psp_pkg::CH_BIG_L) begin
        w.big_l_seen    = 1'b1;
        w.prev_modifier = PM_BIGL;
      end else begin
        emit = 1'b1;
      end
    end

    // plus cancels space, minus cancels zero
    f = w.flag_bits;
    if (f[psp_pkg::FLAG_PLUS]) begin
      f[psp_pkg::FLAG_SPACE] = 1'b0;
    end
    if (f[psp_pkg::FLAG_MINUS]) begin
      f[psp_pkg::FLAG_ZERO] = 1'b0;
    end
    prec_out = w.prec_negative ? '0 : w.prec_acc;

    result_next = {5'b00000, w.count, c, w.big_l_seen, w.long_level,
                   w.short_level, prec_out, w.width_acc, f};

    st_next = emit ? PARSE_RESET : w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= PARSE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (in_fire) begin
        st <= st_next;
      end
      if (in_fire && emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      m_axis_tdata <= result_next;
    end
  end

  // a held result blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // every result counts at least its type byte
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[58:51] != 8'd0))
    else $error("result with zero consumed count");

  // plus and space, minus and zero never leave together
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[4])
                      && !(m_axis_tdata[0] && m_axis_tdata[3]))
    else $error("cancelled flag pair in result");

  // any single flag implies the flag-seen bit
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (|m_axis_tdata[4:0])) |-> m_axis_tdata[5])
    else $error("flag seen bit missing");

  // a new result only follows an accepted item
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_fire))
    else $error("result without accepted item");

endmodule
`default_nettype wire
